[design/fba_pkg.sv]
// Shared types and constants for the frame bitmap allocator.
// Used by fba_ctrl, fba_dpath and frame_bitmap_allocator_top; no dependencies.
`default_nettype none

package fba_pkg;

   // Default sizing of the bitmap
   localparam int MAX_FRAMES = 4096;
   localparam int WORD_BITS  = 32;

   // Field widths of the item payloads and the register
   localparam int KIND_W   = 3;
   localparam int FRAME_W  = 12;
   localparam int COUNT_W  = 13;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 32;
   localparam int PADDR_W  = 3;

   localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 13'd4096;

   // Register index of frame_count
   localparam logic [PADDR_W-3:0] CSR_FRAME_COUNT = 1'b0;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_MARK_USED  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MARK_FREE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TEST       = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ALLOC_ONE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ALLOC_RUN  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_COUNT_USED = 3'd5;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FRAME_W-1:0] frame;
      logic [COUNT_W-1:0] run_length;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FRAME_W-1:0]  frame_index;
      logic                frame_used;
      logic [COUNT_W-1:0]  used_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_LOCATE,
      ST_TEST_RD,
      ST_TEST_BIT,
      ST_SCAN_RD,
      ST_SCAN_BIT,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_REPLY
   } fsm_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic clear_wr;
      logic set_range;
      logic set_no_space;
      logic locate_step;
      logic mem_rd;
      logic test_capture;
      logic scan_step;
      logic mark_wr;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              clear_last;
      logic              out_of_range;
      logic              run_bad;
      logic              located;
      logic              scan_end;
      logic              hit;
      logic              word_end;
      logic              mark_last;
   } stat_type;

endpackage

`default_nettype wire

[design/fba_ctrl.sv]
// Sequencing state machine of the frame bitmap allocator.
// Depends on fba_pkg; drives fba_dpath through cmd_type, reads stat_type.
`default_nettype none

module fba_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              out_free,
   output logic                   rsp_load,
   input  wire fba_pkg::stat_type st,
   output fba_pkg::cmd_type       cmd
);

   fba_pkg::fsm_state_type state_ff;
   fba_pkg::fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fba_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_load  = 1'b0;

      unique case (state_ff)
         fba_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (st.clear_last) begin
               state_in = fba_pkg::ST_IDLE;
            end
         end

         fba_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = fba_pkg::ST_DECODE;
            end
         end

         fba_pkg::ST_DECODE: begin
            unique case (st.kind) inside
               fba_pkg::KIND_MARK_USED, fba_pkg::KIND_MARK_FREE, fba_pkg::KIND_TEST: begin
                  if (st.out_of_range) begin
                     cmd.set_range = 1'b1;
                     state_in      = fba_pkg::ST_REPLY;
                  end else begin
                     state_in = fba_pkg::ST_LOCATE;
                  end
               end
               fba_pkg::KIND_ALLOC_ONE, fba_pkg::KIND_COUNT_USED: begin
                  state_in = fba_pkg::ST_SCAN_RD;
               end
               fba_pkg::KIND_ALLOC_RUN: begin
                  if (st.run_bad) begin
                     cmd.set_no_space = 1'b1;
                     state_in         = fba_pkg::ST_REPLY;
                  end else begin
                     state_in = fba_pkg::ST_SCAN_RD;
                  end
               end
               default: begin
                  state_in = fba_pkg::ST_REPLY;
               end
            endcase
         end

         fba_pkg::ST_LOCATE: begin
            cmd.locate_step = 1'b1;
            if (st.located) begin
               if (st.kind == fba_pkg::KIND_TEST) begin
                  state_in = fba_pkg::ST_TEST_RD;
               end else begin
                  state_in = fba_pkg::ST_MARK_RD;
               end
            end
         end

         fba_pkg::ST_TEST_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = fba_pkg::ST_TEST_BIT;
         end

         fba_pkg::ST_TEST_BIT: begin
            cmd.test_capture = 1'b1;
            state_in         = fba_pkg::ST_REPLY;
         end

         fba_pkg::ST_SCAN_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = fba_pkg::ST_SCAN_BIT;
         end

         fba_pkg::ST_SCAN_BIT: begin
            cmd.scan_step = 1'b1;
            if (st.scan_end) begin
               state_in = fba_pkg::ST_REPLY;
            end else if (st.hit) begin
               state_in = fba_pkg::ST_MARK_RD;
            end else if (st.word_end) begin
               state_in = fba_pkg::ST_SCAN_RD;
            end
         end

         fba_pkg::ST_MARK_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = fba_pkg::ST_MARK_WR;
         end

         fba_pkg::ST_MARK_WR: begin
            cmd.mark_wr = 1'b1;
            if (st.mark_last) begin
               state_in = fba_pkg::ST_REPLY;
            end else begin
               state_in = fba_pkg::ST_MARK_RD;
            end
         end

         fba_pkg::ST_REPLY: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = fba_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = fba_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/fba_dpath.sv]
// Datapath of the frame bitmap allocator: bitmap memory, scan counters,
// run tracking, mark masks and result fields. Depends on fba_pkg.
`default_nettype none

module fba_dpath #(
   parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES,
   parameter int WORD_BITS  = fba_pkg::WORD_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire fba_pkg::req_type             req_data,
   input  wire logic [fba_pkg::COUNT_W-1:0]  frame_count,
   input  wire fba_pkg::cmd_type             cmd,
   output fba_pkg::stat_type                 st,
   output fba_pkg::rsp_type                  result
);

   localparam int WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BIT_W  = $clog2(WORD_BITS);
   localparam int POS_W  = $clog2(MAX_FRAMES + 1);
   localparam int CNT_W  = (POS_W > fba_pkg::COUNT_W) ? POS_W : fba_pkg::COUNT_W;

   // Bitmap store, one bit per frame, 1 = used
   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_wr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [WORD_BITS-1:0] mask;

   logic [fba_pkg::KIND_W-1:0]   kind_ff,       kind_in;
   logic [fba_pkg::FRAME_W-1:0]  req_frame_ff,  req_frame_in;
   logic [fba_pkg::COUNT_W-1:0]  req_run_ff,    req_run_in;
   logic                         set_ff,        set_in;
   logic [POS_W-1:0]             pos_ff,        pos_in;
   logic [ADDR_W-1:0]            word_ff,       word_in;
   logic [BIT_W-1:0]             bit_ff,        bit_in;
   logic [CNT_W-1:0]             run_ff,        run_in;
   logic [POS_W-1:0]             total_ff,      total_in;
   logic [POS_W-1:0]             start_pos_ff,  start_pos_in;
   logic [ADDR_W-1:0]            start_word_ff, start_word_in;
   logic [BIT_W-1:0]             start_bit_ff,  start_bit_in;
   logic [ADDR_W-1:0]            lo_word_ff,    lo_word_in;
   logic [BIT_W-1:0]             lo_bit_ff,     lo_bit_in;
   logic [ADDR_W-1:0]            hi_word_ff,    hi_word_in;
   logic [BIT_W-1:0]             hi_bit_ff,     hi_bit_in;
   logic [fba_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [POS_W-1:0]             res_index_ff,  res_index_in;
   logic                         res_used_ff,   res_used_in;

   logic [CNT_W-1:0]   live;
   logic [CNT_W-1:0]   count_ext;
   logic [CNT_W-1:0]   max_ext;
   logic [CNT_W-1:0]   run_len_ext;
   logic [CNT_W-1:0]   run_next;
   logic [CNT_W:0]     frame_wide;
   logic [CNT_W:0]     pos_wide;
   logic [CNT_W:0]     pos_step;
   logic [CNT_W:0]     offset_full;
   logic [BIT_W-1:0]   offset;
   logic               cur_used;
   logic               fresh_run;
   logic [POS_W-1:0]   lo_pos_sel;
   logic [ADDR_W-1:0]  lo_word_sel;
   logic [BIT_W-1:0]   lo_bit_sel;

   // Effective frame count, saturated to the bitmap size
   assign count_ext   = CNT_W'(frame_count);
   assign max_ext     = CNT_W'(MAX_FRAMES);
   assign live        = (count_ext > max_ext) ? max_ext : count_ext;
   assign run_len_ext = CNT_W'(req_run_ff);
   assign run_next    = run_ff + CNT_W'(1);

   // Walk a word at a time towards the requested frame
   assign frame_wide  = (CNT_W + 1)'(req_frame_ff);
   assign pos_wide    = (CNT_W + 1)'(pos_ff);
   assign pos_step    = pos_wide + (CNT_W + 1)'(WORD_BITS);
   assign offset_full = frame_wide - pos_wide;
   assign offset      = offset_full[BIT_W-1:0];

   assign cur_used  = rd_data_ff[bit_ff];
   assign fresh_run = (run_ff == '0);

   // A run that starts on the current frame has no recorded start yet
   assign lo_pos_sel  = fresh_run ? pos_ff  : start_pos_ff;
   assign lo_word_sel = fresh_run ? word_ff : start_word_ff;
   assign lo_bit_sel  = fresh_run ? bit_ff  : start_bit_ff;

   always_comb begin
      st              = '0;
      st.kind         = kind_ff;
      st.clear_last   = (word_ff == ADDR_W'(WORDS - 1));
      st.out_of_range = (CNT_W'(req_frame_ff) >= live);
      st.run_bad      = (req_run_ff == '0) || (run_len_ext > live);
      st.located      = (frame_wide < pos_step);
      st.scan_end     = (CNT_W'(pos_ff) >= live);
      st.hit          = !cur_used && ((kind_ff == fba_pkg::KIND_ALLOC_ONE) ||
                        ((kind_ff == fba_pkg::KIND_ALLOC_RUN) && (run_next == run_len_ext)));
      st.word_end     = (bit_ff == BIT_W'(WORD_BITS - 1));
      st.mark_last    = (word_ff == hi_word_ff);
   end

   // Bits of the current word that fall inside the range being marked
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         mask[b] = ((word_ff != lo_word_ff) || (BIT_W'(b) >= lo_bit_ff)) &&
                   ((word_ff != hi_word_ff) || (BIT_W'(b) <= hi_bit_ff));
      end
   end

   always_comb begin
      kind_in       = kind_ff;
      req_frame_in  = req_frame_ff;
      req_run_in    = req_run_ff;
      set_in        = set_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      run_in        = run_ff;
      total_in      = total_ff;
      start_pos_in  = start_pos_ff;
      start_word_in = start_word_ff;
      start_bit_in  = start_bit_ff;
      lo_word_in    = lo_word_ff;
      lo_bit_in     = lo_bit_ff;
      hi_word_in    = hi_word_ff;
      hi_bit_in     = hi_bit_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_used_in   = res_used_ff;
      mem_wr        = 1'b0;
      mem_wdata     = '0;

      if (cmd.load) begin
         kind_in       = req_data.kind;
         req_frame_in  = req_data.frame;
         req_run_in    = req_data.run_length;
         set_in        = (req_data.kind != fba_pkg::KIND_MARK_FREE);
         pos_in        = '0;
         word_in       = '0;
         bit_in        = '0;
         run_in        = '0;
         total_in      = '0;
         res_status_in = fba_pkg::STATUS_OK;
         res_index_in  = '0;
         res_used_in   = 1'b0;
      end

      if (cmd.clear_wr) begin
         mem_wr  = 1'b1;
         word_in = st.clear_last ? '0 : word_ff + ADDR_W'(1);
      end

      if (cmd.set_range) begin
         res_status_in = fba_pkg::STATUS_RANGE;
      end

      if (cmd.set_no_space) begin
         res_status_in = fba_pkg::STATUS_NO_SPACE;
      end

      if (cmd.locate_step) begin
         if (st.located) begin
            bit_in     = offset;
            lo_word_in = word_ff;
            hi_word_in = word_ff;
            lo_bit_in  = offset;
            hi_bit_in  = offset;
         end else begin
            pos_in  = POS_W'(pos_step);
            word_in = word_ff + ADDR_W'(1);
         end
      end

      if (cmd.test_capture) begin
         res_used_in = cur_used;
      end

      if (cmd.scan_step) begin
         if (st.scan_end) begin
            res_status_in = (kind_ff == fba_pkg::KIND_COUNT_USED) ?
                            fba_pkg::STATUS_OK : fba_pkg::STATUS_NO_SPACE;
         end else begin
            if (cur_used) begin
               run_in = '0;
               if (kind_ff == fba_pkg::KIND_COUNT_USED) begin
                  total_in = total_ff + POS_W'(1);
               end
            end else begin
               run_in = run_next;
               if (fresh_run) begin
                  start_pos_in  = pos_ff;
                  start_word_in = word_ff;
                  start_bit_in  = bit_ff;
               end
            end

            if (st.hit) begin
               lo_word_in   = lo_word_sel;
               lo_bit_in    = lo_bit_sel;
               hi_word_in   = word_ff;
               hi_bit_in    = bit_ff;
               word_in      = lo_word_sel;
               res_index_in = lo_pos_sel;
            end else if (st.word_end) begin
               pos_in  = pos_ff + POS_W'(1);
               word_in = word_ff + ADDR_W'(1);
               bit_in  = '0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
               bit_in = bit_ff + BIT_W'(1);
            end
         end
      end

      if (cmd.mark_wr) begin
         mem_wr    = 1'b1;
         mem_wdata = set_ff ? (rd_data_ff | mask) : (rd_data_ff & ~mask);
         if (!st.mark_last) begin
            word_in = word_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[word_ff] <= mem_wdata;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[word_ff];
      end
   end

   // The word counter also drives the clearing pass, so it is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      req_frame_ff  <= req_frame_in;
      req_run_ff    <= req_run_in;
      set_ff        <= set_in;
      pos_ff        <= pos_in;
      bit_ff        <= bit_in;
      run_ff        <= run_in;
      total_ff      <= total_in;
      start_pos_ff  <= start_pos_in;
      start_word_ff <= start_word_in;
      start_bit_ff  <= start_bit_in;
      lo_word_ff    <= lo_word_in;
      lo_bit_ff     <= lo_bit_in;
      hi_word_ff    <= hi_word_in;
      hi_bit_ff     <= hi_bit_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_used_ff   <= res_used_in;
   end

   assign result.status      = res_status_ff;
   assign result.frame_index = fba_pkg::FRAME_W'(res_index_ff);
   assign result.frame_used  = res_used_ff;
   assign result.used_count  = fba_pkg::COUNT_W'(total_ff);

endmodule

`default_nettype wire

[design/frame_bitmap_allocator_top.sv]
// Frame bitmap allocator: used/free bitmap of physical page frames.
//
// Requests arrive on req_valid/req_stall/req_data, one item per request;
// each gives exactly one result on rsp_valid/rsp_stall/rsp_data.
// An item is taken when valid is high and stall is low. frame_count is
// set through the APB port (byte address 0); the user must do so only
// while idle, which the block itself does not enforce.
//
// After reset the bitmap memory is swept to zero, one word a cycle;
// requests stall meanwhile while register writes are taken as usual.
//
// One item is worked on at a time through a single-port memory with
// registered read; a scan looks at one bitmap bit per cycle, apart from
// a read at the start of each word. Mark and test step a word at a time
// to the frame's word; allocate and count scan the frames in order, and
// allocate then marks its run with a read and a write of each word; the
// frame count bounds a full scan. The result sits in an output register,
// so the next item is accepted while it waits; a stalled receiver only
// holds the block once the following result is ready.
// Depends on fba_pkg, fba_ctrl and fba_dpath.
`default_nettype none

module frame_bitmap_allocator_top #(
   parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES,
   parameter int WORD_BITS  = fba_pkg::WORD_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire fba_pkg::req_type              req_data,

   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output fba_pkg::rsp_type                   rsp_data,

   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [fba_pkg::PADDR_W-1:0]   paddr,
   input  wire logic [fba_pkg::CSR_W-1:0]     pwdata,
   output logic [fba_pkg::CSR_W-1:0]          prdata,
   output logic                               pready
);

   logic [fba_pkg::COUNT_W-1:0] frame_count_ff, frame_count_in;
   logic                        rsp_valid_ff,   rsp_valid_in;
   fba_pkg::rsp_type            rsp_data_ff,    rsp_data_in;

   fba_pkg::cmd_type  cmd;
   fba_pkg::stat_type st;
   fba_pkg::rsp_type  result;
   logic              rsp_load;
   logic              out_free;
   logic              csr_hit;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[fba_pkg::PADDR_W-1:2] == fba_pkg::CSR_FRAME_COUNT);

   always_comb begin
      frame_count_in = frame_count_ff;
      if (psel && penable && pwrite && csr_hit) begin
         frame_count_in = pwdata[fba_pkg::COUNT_W-1:0];
      end
   end

   assign prdata = csr_hit ? fba_pkg::CSR_W'(frame_count_ff) : '0;

   // Output slot frees when empty or when its item leaves this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= fba_pkg::FRAME_COUNT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_count_ff <= frame_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   fba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .rsp_load  (rsp_load),
      .st        (st),
      .cmd       (cmd)
   );

   fba_dpath #(
      .MAX_FRAMES (MAX_FRAMES),
      .WORD_BITS  (WORD_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .frame_count (frame_count_ff),
      .cmd         (cmd),
      .st          (st),
      .result      (result)
   );

endmodule

`default_nettype wire
